FILE: design/ocs_pkg.sv
// shared constants, types and codes for the open/closed syncmer classifier
// no dependencies; every other design file refers to it by scoped names
package ocs_pkg;

    // sizing
    localparam int SMER_LEN   = 4;
    localparam int MAX_K      = 32;
    localparam int RING_DEPTH = 128;

    localparam int KMER_W      = 64;
    localparam int NUC_W       = 2;
    localparam int SMER_BITS   = 2 * SMER_LEN;
    localparam int KEY_W       = SMER_BITS + 1;
    localparam int CELL_W      = $clog2(MAX_K);
    localparam int STEP_CNT_W  = $clog2(MAX_K + 1);
    localparam int POS_W       = 5;
    localparam int CLASS_W     = 2;
    localparam int KLEN_W      = 6;
    localparam int WLEN_W      = 8;
    localparam int OUT_SUM_W   = 9;
    localparam int RING_PTR_W  = $clog2(RING_DEPTH);
    localparam int RING_CNT_W  = $clog2(RING_DEPTH + 1);
    localparam int SUM_RAW_W   = $clog2(3 * RING_DEPTH + 1);
    localparam int SUM_ACC_W   = (SUM_RAW_W > OUT_SUM_W) ? SUM_RAW_W : OUT_SUM_W;

    localparam logic [KMER_W-1:0]    S_SEED  = 64'h9e3779b97f4a7c15;
    localparam logic [KMER_W-1:0]    K_SEED  = 64'hBF58476D1CE4E5B9;
    localparam logic [OUT_SUM_W-1:0] SUM_MAX = '1;

    // configuration
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 8;
    localparam logic [CFG_INDEX_W-1:0] CFG_KMER_LENGTH   = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_WINDOW_LENGTH = 1'd1;
    localparam logic [KLEN_W-1:0] KMER_LENGTH_RESET   = 6'd12;
    localparam logic [WLEN_W-1:0] WINDOW_LENGTH_RESET = 8'd24;

    // class codes
    localparam logic [CLASS_W-1:0] CLS_OPEN    = 2'd1;
    localparam logic [CLASS_W-1:0] CLS_CLOSED  = 2'd2;
    localparam logic [CLASS_W-1:0] CLS_NEITHER = 2'd3;

    // running minimum handed from an older cell to a newer one
    typedef struct packed {
        logic             found;
        logic [KEY_W-1:0] key;
        logic [POS_W-1:0] pos;
    } min_link_t;

    // commands into the class ring
    typedef struct packed {
        logic               start;
        logic               commit;
        logic [CLASS_W-1:0] cls;
    } ring_cmd_t;

    // status out of the class ring
    typedef struct packed {
        logic                 done;
        logic [SUM_ACC_W-1:0] older_sum;
    } ring_status_t;

endpackage

FILE: design/ocs_channels.sv
// valid/ready channel interfaces for nucleotide input and classifier results
// depends on ocs_pkg for field widths
interface ocs_in_if;
    logic                         valid;
    logic                         ready;
    logic [ocs_pkg::NUC_W-1:0]    nucleotide;

    modport source (output valid, output nucleotide, input ready);
    modport sink   (input valid, input nucleotide, output ready);
endinterface

interface ocs_out_if;
    logic                           valid;
    logic                           ready;
    logic [ocs_pkg::CLASS_W-1:0]    syncmer_class;
    logic [ocs_pkg::POS_W-1:0]      min_position;
    logic [ocs_pkg::KMER_W-1:0]     kmer_hash;
    logic [ocs_pkg::OUT_SUM_W-1:0]  window_class_sum;

    modport source (output valid, output syncmer_class, output min_position,
                    output kmer_hash, output window_class_sum, input ready);
    modport sink   (input valid, input syncmer_class, input min_position,
                    input kmer_hash, input window_class_sum, output ready);
endinterface

FILE: design/ocs_cell.sv
// one history cell: holds an s-mer key and folds it into the running minimum
// depends on ocs_pkg (key width, min_link_t)
module ocs_cell (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        shift,
    input  logic [ocs_pkg::KEY_W-1:0]   key_in,
    input  ocs_pkg::min_link_t          link_in,
    input  logic [ocs_pkg::CELL_W-1:0]  cell_index,
    input  logic [ocs_pkg::CELL_W-1:0]  last_pos,
    output logic [ocs_pkg::KEY_W-1:0]   key,
    output ocs_pkg::min_link_t          link_out
);

    logic [ocs_pkg::KEY_W-1:0] key_reg;
    logic [ocs_pkg::KEY_W-1:0] key_next;
    ocs_pkg::min_link_t        link_reg;
    ocs_pkg::min_link_t        link_next;
    logic                      in_window;
    logic                      take_own;

    assign in_window = (cell_index <= last_pos);
    // older neighbor wins ties, so only a strictly smaller key replaces it
    assign take_own  = !link_in.found || (key_reg < link_in.key);

    always_comb
    begin
        key_next  = shift ? key_in : key_reg;
        link_next = link_in;
        if (in_window && take_own)
        begin
            link_next.found = 1'b1;
            link_next.key   = key_reg;
            link_next.pos   = ocs_pkg::POS_W'(last_pos - cell_index);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg  <= '0;
            link_reg <= '0;
        end
        else
        begin
            key_reg  <= key_next;
            link_reg <= link_next;
        end
    end

    assign key      = key_reg;
    assign link_out = link_reg;

endmodule

FILE: design/ocs_ring_sum.sv
// class ring memory with write pointer, fill flag and window sum sweep
// depends on ocs_pkg (ring sizing, ring_cmd_t, ring_status_t)
module ocs_ring_sum (
    input  logic                            clk,
    input  logic                            rst_n,
    input  ocs_pkg::ring_cmd_t              cmd,
    input  logic [ocs_pkg::RING_CNT_W-1:0]  window,
    output ocs_pkg::ring_status_t           status
);

    localparam int AW = ocs_pkg::RING_CNT_W + 1;

    logic [ocs_pkg::CLASS_W-1:0]    mem [ocs_pkg::RING_DEPTH];
    logic [ocs_pkg::RING_PTR_W-1:0] ptr_reg,  ptr_next;
    logic                           full_reg, full_next;
    logic                           busy_reg, busy_next;
    logic [ocs_pkg::RING_CNT_W-1:0] back_reg, back_next;
    logic                           pend_reg, pend_next;
    logic                           live_reg, live_next;
    logic [ocs_pkg::SUM_ACC_W-1:0]  acc_reg,  acc_next;
    logic [ocs_pkg::CLASS_W-1:0]    rd_data_reg;
    logic [AW-1:0]                  ptr_ext;
    logic [AW-1:0]                  back_ext;
    logic [AW-1:0]                  addr_ext;
    logic [ocs_pkg::RING_PTR_W-1:0] rd_addr;

    assign ptr_ext  = AW'(ptr_reg);
    assign back_ext = AW'(back_reg);
    assign addr_ext = (ptr_ext >= back_ext) ? (ptr_ext - back_ext)
                                            : (ptr_ext + AW'(ocs_pkg::RING_DEPTH) - back_ext);
    assign rd_addr  = addr_ext[ocs_pkg::RING_PTR_W-1:0];

    always_comb
    begin
        ptr_next  = ptr_reg;
        full_next = full_reg;
        busy_next = busy_reg;
        back_next = back_reg;
        pend_next = busy_reg;
        live_next = full_reg || (rd_addr < ptr_reg);
        acc_next  = acc_reg;

        if (pend_reg && live_reg)
            acc_next = acc_reg + ocs_pkg::SUM_ACC_W'(rd_data_reg);

        if (busy_reg)
        begin
            if (back_reg == window - ocs_pkg::RING_CNT_W'(1))
                busy_next = 1'b0;
            else
                back_next = back_reg + ocs_pkg::RING_CNT_W'(1);
        end

        if (cmd.start)
        begin
            // entries one back through window-1 back; the newest comes in at commit
            acc_next  = '0;
            back_next = ocs_pkg::RING_CNT_W'(1);
            busy_next = (window > ocs_pkg::RING_CNT_W'(1));
            pend_next = 1'b0;
        end

        if (cmd.commit)
        begin
            if (ptr_reg == ocs_pkg::RING_PTR_W'(ocs_pkg::RING_DEPTH - 1))
            begin
                ptr_next  = '0;
                full_next = 1'b1;
            end
            else
                ptr_next = ptr_reg + ocs_pkg::RING_PTR_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg  <= '0;
            full_reg <= 1'b0;
            busy_reg <= 1'b0;
            back_reg <= '0;
            pend_reg <= 1'b0;
            live_reg <= 1'b0;
            acc_reg  <= '0;
        end
        else
        begin
            ptr_reg  <= ptr_next;
            full_reg <= full_next;
            busy_reg <= busy_next;
            back_reg <= back_next;
            pend_reg <= pend_next;
            live_reg <= live_next;
            acc_reg  <= acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
            mem[ptr_reg] <= cmd.cls;
        if (busy_reg)
            rd_data_reg <= mem[rd_addr];
    end

    assign status.done      = !busy_reg && !pend_reg;
    assign status.older_sum = acc_reg;

endmodule

FILE: design/open_closed_syncmer_classifier_unit.sv
// top level of the open/closed syncmer classifier
// depends on ocs_pkg, ocs_channels (ocs_in_if, ocs_out_if), ocs_cell, ocs_ring_sum
//
// One nucleotide per transaction on sample, one result per nucleotide on result.
// The block works on one transaction at a time. Acceptance shifts the base into
// the rolling k-mer and shifts the new s-mer key into a chain of MAX_K history
// cells; the running minimum then ripples from the oldest cell to the newest,
// one cell per clock, through all MAX_K cells. In parallel the class ring
// sweeps its w-1 older entries, one memory read per cycle (w = window_length
// saturated to the ring depth). The result is registered at commit, once the
// ripple and the sweep are done and the output register is free; sample.ready
// returns with it, so no nucleotide is taken before that. A result that waits on
// result.ready does not hold off the next transaction, only the next commit.
// Reset clears the history cells and marks the ring empty through its fill flag;
// there is no clearing pass. Configuration writes go on cfg_write_en / cfg_index
// / cfg_data and should only be issued while the block is idle.
module open_closed_syncmer_classifier_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    ocs_in_if.sink                            sample,
    ocs_out_if.source                         result,
    input  logic                              cfg_write_en,
    input  logic [ocs_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [ocs_pkg::CFG_DATA_W-1:0]    cfg_data
);

    // sequencer codes
    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_BUSY = 1'b1;

    logic                             state_reg, state_next;
    logic [ocs_pkg::STEP_CNT_W-1:0]   cnt_reg, cnt_next;
    logic [ocs_pkg::KLEN_W-1:0]       kmer_length_reg;
    logic [ocs_pkg::WLEN_W-1:0]       window_length_reg;
    logic [ocs_pkg::KMER_W-1:0]       kmer_reg, kmer_next;

    // output register
    logic                             out_valid_reg, out_valid_next;
    logic [ocs_pkg::CLASS_W-1:0]      out_class_reg;
    logic [ocs_pkg::POS_W-1:0]        out_pos_reg;
    logic [ocs_pkg::KMER_W-1:0]       out_hash_reg;
    logic [ocs_pkg::OUT_SUM_W-1:0]    out_sum_reg;

    logic                             accept;
    logic                             commit;
    logic [ocs_pkg::KLEN_W-1:0]       k_sat;
    logic [ocs_pkg::RING_CNT_W-1:0]   w_sat;
    logic [ocs_pkg::CELL_W-1:0]       last_pos;
    logic [ocs_pkg::CELL_W-1:0]       mid_pos;
    logic [ocs_pkg::KMER_W-1:0]       kmask;
    logic [ocs_pkg::KEY_W-1:0]        new_key;
    logic [ocs_pkg::CLASS_W-1:0]      cls;
    logic [ocs_pkg::POS_W-1:0]        min_pos;
    logic [ocs_pkg::SUM_ACC_W:0]      total;
    logic [ocs_pkg::OUT_SUM_W-1:0]    sum_sat;

    logic [ocs_pkg::KEY_W-1:0]        keys  [ocs_pkg::MAX_K];
    ocs_pkg::min_link_t               links [ocs_pkg::MAX_K+1];
    ocs_pkg::ring_cmd_t               ring_cmd;
    ocs_pkg::ring_status_t            ring_status;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kmer_length_reg   <= ocs_pkg::KMER_LENGTH_RESET;
            window_length_reg <= ocs_pkg::WINDOW_LENGTH_RESET;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                ocs_pkg::CFG_KMER_LENGTH:
                    kmer_length_reg   <= cfg_data[ocs_pkg::KLEN_W-1:0];
                ocs_pkg::CFG_WINDOW_LENGTH:
                    window_length_reg <= cfg_data[ocs_pkg::WLEN_W-1:0];
            endcase
        end
    end

    // saturated k and w, window geometry
    always_comb
    begin
        if (kmer_length_reg < ocs_pkg::KLEN_W'(ocs_pkg::SMER_LEN))
            k_sat = ocs_pkg::KLEN_W'(ocs_pkg::SMER_LEN);
        else if (kmer_length_reg > ocs_pkg::KLEN_W'(ocs_pkg::MAX_K))
            k_sat = ocs_pkg::KLEN_W'(ocs_pkg::MAX_K);
        else
            k_sat = kmer_length_reg;

        if (ocs_pkg::RING_CNT_W'(window_length_reg) > ocs_pkg::RING_CNT_W'(ocs_pkg::RING_DEPTH))
            w_sat = ocs_pkg::RING_CNT_W'(ocs_pkg::RING_DEPTH);
        else
            w_sat = ocs_pkg::RING_CNT_W'(window_length_reg);
    end

    // last window position is k - s, the middle one half of that
    assign last_pos = ocs_pkg::CELL_W'(k_sat - ocs_pkg::KLEN_W'(ocs_pkg::SMER_LEN));
    assign mid_pos  = last_pos >> 1;

    // k-mer mask, two bits per nucleotide below k
    always_comb
    begin
        for (int n = 0; n < ocs_pkg::KMER_W / 2; n++)
            kmask[2*n +: 2] = (n < int'(k_sat)) ? 2'b11 : 2'b00;
    end

    assign kmer_next = {kmer_reg[ocs_pkg::KMER_W-3:0], sample.nucleotide} & kmask;

    // key order matches hash order: never-written is 0, written keys carry
    // the top bit and the low seed bits (the upper seed bits are common)
    assign new_key = {1'b1, kmer_next[ocs_pkg::SMER_BITS-1:0]
                            ^ ocs_pkg::S_SEED[ocs_pkg::SMER_BITS-1:0]};

    // history chain, cell 0 newest; minimum ripples from the oldest end
    assign links[ocs_pkg::MAX_K] = '0;

    for (genvar i = 0; i < ocs_pkg::MAX_K; i++)
    begin : g_cell
        ocs_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .shift      (accept),
            .key_in     ((i == 0) ? new_key : keys[(i == 0) ? 0 : i - 1]),
            .link_in    (links[i+1]),
            .cell_index (ocs_pkg::CELL_W'(i)),
            .last_pos   (last_pos),
            .key        (keys[i]),
            .link_out   (links[i])
        );
    end

    assign min_pos = links[0].pos;

    // open wins over closed
    always_comb
    begin
        priority if (ocs_pkg::CELL_W'(min_pos) == mid_pos)
            cls = ocs_pkg::CLS_OPEN;
        else if (min_pos == '0 || ocs_pkg::CELL_W'(min_pos) == last_pos)
            cls = ocs_pkg::CLS_CLOSED;
        else
            cls = ocs_pkg::CLS_NEITHER;
    end

    // class ring and window sum
    assign ring_cmd.start  = accept;
    assign ring_cmd.commit = commit;
    assign ring_cmd.cls    = cls;

    ocs_ring_sum u_ring (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (ring_cmd),
        .window (w_sat),
        .status (ring_status)
    );

    // newest class counts only when the window is not empty
    assign total   = (w_sat == '0) ? '0
                   : ((ocs_pkg::SUM_ACC_W+1)'(ring_status.older_sum)
                      + (ocs_pkg::SUM_ACC_W+1)'(cls));
    assign sum_sat = (total > (ocs_pkg::SUM_ACC_W+1)'(ocs_pkg::SUM_MAX)) ? ocs_pkg::SUM_MAX
                   : total[ocs_pkg::OUT_SUM_W-1:0];

    // sequencer
    assign accept = sample.valid && sample.ready;
    assign commit = (state_reg == ST_BUSY)
                 && (cnt_reg == ocs_pkg::STEP_CNT_W'(ocs_pkg::MAX_K))
                 && ring_status.done
                 && (!out_valid_reg || result.ready);

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;

        if (out_valid_reg && result.ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_BUSY;
                    cnt_next   = '0;
                end
            end
            ST_BUSY:
            begin
                if (cnt_reg != ocs_pkg::STEP_CNT_W'(ocs_pkg::MAX_K))
                    cnt_next = cnt_reg + ocs_pkg::STEP_CNT_W'(1);
                if (commit)
                begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            kmer_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            if (accept)
                kmer_reg <= kmer_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            out_class_reg <= cls;
            out_pos_reg   <= min_pos;
            out_hash_reg  <= kmer_reg ^ ocs_pkg::K_SEED;
            out_sum_reg   <= sum_sat;
        end
    end

    assign sample.ready            = (state_reg == ST_IDLE);
    assign result.valid            = out_valid_reg;
    assign result.syncmer_class    = out_class_reg;
    assign result.min_position     = out_pos_reg;
    assign result.kmer_hash        = out_hash_reg;
    assign result.window_class_sum = out_sum_reg;

    // a new result only ever comes out of the busy state
    a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result.valid) |-> $past(state_reg == ST_BUSY))
        else $error("result raised without a finished item");

    // one transaction at a time
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !sample.ready)
        else $error("input accepted while an item is at work");

    // commit needs the full ripple through the cell chain
    a_commit_after_ripple: assert property (@(posedge clk) disable iff (!rst_n)
        commit |-> $past(state_reg == ST_BUSY, ocs_pkg::MAX_K))
        else $error("commit before the minimum reached the newest cell");

    // a delivered minimum lies inside the window
    a_pos_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (ocs_pkg::CELL_W'(result.min_position) <= last_pos))
        else $error("min position beyond the window");

endmodule
